/* hw/rtl/pdsf_pkg.sv */
`default_nettype none
package pdsf_pkg;

   localparam int FracBits = 16;
   localparam int MaxSteps = 1024;
   localparam int StepBits = $clog2(MaxSteps + 1);
   localparam int CsrIdxBits = 3;
   localparam int QueueDepth = 2;

   // Configuration register indexes.
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_GAIN_P   = 3'd0,
      CSR_GAIN_D   = 3'd1,
      CSR_DRY      = 3'd2,
      CSR_VISCOUS  = 3'd3,
      CSR_STEP     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [30:0]        inv_mass;
      logic signed [31:0] damping;
      logic signed [31:0] stiffness;
      logic signed [31:0] bias_force;
      logic signed [31:0] start_pos;
      logic signed [31:0] start_vel;
      logic signed [31:0] target_pos;
      logic signed [31:0] target_vel;
      logic [30:0]        duration;
   } req_type;

   typedef struct packed {
      logic signed [31:0] end_pos;
      logic signed [31:0] end_vel;
      logic               truncated;
   } rsp_type;

   // Classified request as stored in the queue between front and back.
   typedef struct packed {
      req_type     req;
      logic        no_step;
   } job_type;

   typedef struct packed {
      logic [30:0] gain_p;
      logic [30:0] gain_d;
      logic [30:0] dry_friction;
      logic [30:0] viscous_friction;
      logic [30:0] step_time;
   } csr_type;

   // Back-end sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE, ST_ERR, ST_PD1, ST_PD2, ST_PD3, ST_PD4, ST_F0, ST_A0, ST_KF,
      ST_KF2, ST_DT, ST_SDIV, ST_SDIVW, ST_FDIV, ST_FDIVW, ST_SLIP, ST_SLIP2,
      ST_XV1, ST_XV2, ST_XV3, ST_UPD, ST_DONE
   } st_type;

   function automatic logic signed [63:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) sat32 = 64'sd2147483647;
      else if (v < lo) sat32 = -64'sd2147483648;
      else sat32 = v[63:0];
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/pdsf_div.sv */
`default_nettype none
// Signed 64 by unsigned 32 bit divider, one quotient bit a cycle, truncating toward zero.
module pdsf_div
   import pdsf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic [31:0]        divisor,
   output logic                    busy,
   output logic signed [63:0]      quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      if (start) begin
         quo_in = dividend[63] ? 64'(-dividend) : dividend;
         rem_in = '0;
         dsr_in = divisor;
         neg_in = dividend[63];
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift one dividend bit in and try a subtract.
         trial = {rem_ff[31:0], quo_ff[63]};
         quo_in = {quo_ff[62:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff | start;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
`default_nettype wire

/* hw/rtl/pdsf_front.sv */
`default_nettype none
// Front end: accepts requests, classifies them and holds them in a short queue.
module pdsf_front
   import pdsf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   input  wire logic    job_take,
   output logic         job_valid,
   output job_type      job
);
   localparam int PtrBits = $clog2(QueueDepth);
   job_type              mem_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ff, rd_ff;
   logic [PtrBits:0]     cnt_ff;
   logic                 do_push, do_pop;
   job_type              new_job;

   assign full = (cnt_ff == (PtrBits+1)'(QueueDepth));
   assign job_valid = (cnt_ff != '0);
   assign do_push = push & ~full;
   assign do_pop = job_take & job_valid;
   assign job = mem_ff[rd_ff];

   // A zero duration runs no step.
   always_comb begin
      new_job.req = req_data;
      new_job.no_step = (req_data.duration == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
      end
      if (do_push) mem_ff[wr_ff] <= new_job;
   end

   assert property (@(posedge clock) disable iff (reset)
      full |-> cnt_ff == (PtrBits+1)'(QueueDepth)) else $error("queue count");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push count");
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("pop count");
endmodule
`default_nettype wire

/* hw/rtl/pdsf_back.sv */
`default_nettype none
// Back end: steps the joint model, at most one multiply per state, divisions on a shared unit.
module pdsf_back
   import pdsf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire csr_type csr,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_take,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    rsp_take
);
   st_type st_ff, st_in;
   logic signed [63:0] x_ff, v_ff, acc_ff, a0_ff, kf_ff, dt_ff, s_ff, a_ff, q_ff, st_t_ff;
   logic signed [63:0] x_in, v_in, acc_in, a0_in, kf_in, dt_in, s_in, a_in, q_in, st_t_in;
   logic [31:0] el_ff, el_in;
   logic [StepBits-1:0] n_ff, n_in;
   req_type r_ff, r_in;
   rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [63:0] mq;
   logic div_start, div_busy;
   logic signed [63:0] div_num, quo;
   logic [31:0] div_den;
   logic signed [63:0] minv, ep, ev, rem, ff;

   pdsf_div u_div (.clock, .reset, .start(div_start), .dividend(div_num),
                   .divisor(div_den), .busy(div_busy), .quotient(quo));

   // Shared 33 x 33 bit multiplier with floor scaling.
   assign prod = ma * mb;
   assign mq = 64'(prod >>> FracBits);
   assign minv = {33'd0, r_ff.inv_mass};

   always_comb begin
      st_in = st_ff; x_in = x_ff; v_in = v_ff; acc_in = acc_ff; a0_in = a0_ff;
      kf_in = kf_ff; dt_in = dt_ff; s_in = s_ff; a_in = a_ff; q_in = q_ff;
      st_t_in = st_t_ff; el_in = el_ff; n_in = n_ff; r_in = r_ff;
      out_in = out_ff; out_v_in = out_v_ff;
      ma = '0; mb = '0; div_start = 1'b0; div_num = '0; div_den = '0;
      job_take = 1'b0;
      ep = sat32(66'(r_ff.target_pos) - 66'(x_ff));
      ev = sat32(66'(r_ff.target_vel) - 66'(v_ff));
      rem = 64'(r_ff.duration) - 64'(el_ff);
      ff = (v_ff > 0) ? -kf_ff : ((v_ff < 0) ? kf_ff : 64'sd0);
      if (out_v_ff && rsp_take) out_v_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (job_valid && !out_v_in) begin
               job_take = 1'b1;
               r_in = job.req;
               x_in = 64'(job.req.start_pos);
               v_in = 64'(job.req.start_vel);
               el_in = '0;
               n_in = '0;
               st_t_in = (csr.step_time == '0) ? 64'sd1 : 64'(csr.step_time);
               st_in = job.no_step ? ST_DONE : ST_ERR;
            end
         end
         ST_ERR: begin
            ma = 33'(st_t_ff); mb = 33'(st_t_ff);
            q_in = (mq > 64'sd2147483647) ? 64'sd2147483647 : mq;
            st_in = ST_PD1;
         end
         ST_PD1: begin
            ma = 33'(csr.gain_p); mb = 33'(ep); acc_in = mq; st_in = ST_PD2;
         end
         ST_PD2: begin
            ma = 33'(csr.gain_d); mb = 33'(ev); acc_in = acc_ff + mq; st_in = ST_PD3;
         end
         ST_PD3: begin
            ma = 33'(r_ff.damping); mb = 33'(v_ff); acc_in = acc_ff - mq; st_in = ST_PD4;
         end
         ST_PD4: begin
            ma = 33'(r_ff.stiffness); mb = 33'(x_ff); acc_in = acc_ff - mq; st_in = ST_F0;
         end
         ST_F0: begin
            acc_in = sat32(66'(acc_ff) - 66'(r_ff.bias_force)); st_in = ST_A0;
         end
         ST_A0: begin
            ma = 33'(acc_ff); mb = 33'(minv); a0_in = sat32(66'(mq)); st_in = ST_KF;
         end
         ST_KF: begin
            ma = 33'(v_ff[63] ? -v_ff : v_ff); mb = 33'(csr.viscous_friction);
            kf_in = 64'(csr.dry_friction) + mq;
            st_in = ST_KF2;
         end
         ST_KF2: begin
            if (kf_ff > 64'sd2147483647) kf_in = 64'sd2147483647;
            dt_in = (rem > st_t_ff) ? st_t_ff : rem;
            a_in = a0_ff;
            st_in = ST_DT;
         end
         ST_DT: begin
            if (kf_ff > 0) begin
               div_start = 1'b1;
               div_num = (-v_ff) <<< FracBits;
               div_den = dt_ff[31:0];
               st_in = ST_SDIV;
            end else begin
               st_in = ST_XV1;
            end
         end
         ST_SDIV: st_in = ST_SDIVW;
         ST_SDIVW: begin
            if (!div_busy) begin
               s_in = sat32(66'(quo));
               st_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (r_ff.inv_mass == '0) begin
               st_in = ST_SLIP;
            end else begin
               div_start = 1'b1;
               div_num = (s_ff - a0_ff) <<< FracBits;
               div_den = {1'b0, r_ff.inv_mass};
               st_in = ST_FDIVW;
            end
         end
         ST_FDIVW: begin
            if (!div_busy && !div_start) begin
               if ((quo[63] ? -quo : quo) > kf_ff) st_in = ST_SLIP;
               else begin
                  a_in = s_ff;
                  st_in = ST_XV1;
               end
            end
         end
         ST_SLIP: begin
            ma = 33'(ff); mb = 33'(minv); a_in = mq; st_in = ST_SLIP2;
         end
         ST_SLIP2: begin
            a_in = sat32(66'(a0_ff) + 66'(a_ff)); st_in = ST_XV1;
         end
         ST_XV1: begin
            ma = 33'(v_ff); mb = 33'(dt_ff); acc_in = x_ff + mq; st_in = ST_XV2;
         end
         ST_XV2: begin
            ma = 33'(a_ff); mb = 33'(q_ff);
            x_in = sat32(66'(acc_ff) + 66'(prod >>> (FracBits + 1)));
            st_in = ST_XV3;
         end
         ST_XV3: begin
            ma = 33'(a_ff); mb = 33'(dt_ff);
            v_in = sat32(66'(v_ff) + 66'(mq));
            st_in = ST_UPD;
         end
         ST_UPD: begin
            el_in = el_ff + dt_ff[31:0];
            n_in = n_ff + 1'b1;
            if (el_in < 32'(r_ff.duration) && n_in < StepBits'(MaxSteps)) st_in = ST_PD1;
            else st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_v_in) begin
               out_in.end_pos = x_ff[31:0];
               out_in.end_vel = v_ff[31:0];
               out_in.truncated = (el_ff < 32'(r_ff.duration));
               out_v_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
      end
      x_ff <= x_in; v_ff <= v_in; acc_ff <= acc_in; a0_ff <= a0_in; kf_ff <= kf_in;
      dt_ff <= dt_in; s_ff <= s_in; a_ff <= a_in; q_ff <= q_in; st_t_ff <= st_t_in;
      el_ff <= el_in; n_ff <= n_in; r_ff <= r_in; out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_take) |=> out_v_ff && $stable(out_ff)) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      job_take |-> st_ff == ST_IDLE) else $error("take while busy");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_SDIV) |-> div_busy) else $error("divider idle");
endmodule
`default_nettype wire

/* hw/rtl/pd_servo_friction_joint_sim_top.sv */
`default_nettype none
// Channel   | ports                          | moves
// request   | push, full, req_data           | one joint model and run
// response  | pop, empty, rsp_data           | end state and truncation flag
// csr       | csr_valid, csr_ready, csr_*    | register index and value
//
// A request passes through take, setup and hand-off plus its steps; a zero
// duration runs no step. With a zero friction limit a step does not use the
// shared divider, else it waits on it twice for the stick/slip test, once only
// when the inverse mass is zero. Reset is synchronous and clears the
// queue and sequencer. A stalled response holds the back end; the front
// queue still takes up to two requests.
module pd_servo_friction_joint_sim_top
   import pdsf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [CsrIdxBits-1:0] csr_index,
   input  wire logic [30:0] csr_data
);
   csr_type csr_ff;
   logic    job_valid, job_take, rsp_valid;
   job_type job;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{gain_p: '0, gain_d: '0, dry_friction: '0,
                     viscous_friction: '0, step_time: 31'd66};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:  csr_ff.gain_p <= csr_data;
            CSR_GAIN_D:  csr_ff.gain_d <= csr_data;
            CSR_DRY:     csr_ff.dry_friction <= csr_data;
            CSR_VISCOUS: csr_ff.viscous_friction <= csr_data;
            CSR_STEP:    csr_ff.step_time <= csr_data;
            default: ;
         endcase
      end
   end

   pdsf_front u_front (.clock, .reset, .push, .req_data, .full,
                       .job_take, .job_valid, .job);

   pdsf_back u_back (.clock, .reset, .csr(csr_ff), .job_valid, .job, .job_take,
                     .rsp_valid, .rsp_data, .rsp_take(pop));

   assign empty = ~rsp_valid;
endmodule
`default_nettype wire
